// ===== src/apdc_pkg.sv =====
`timescale 1ns / 1ps

package apdc_pkg;

  // field widths
  localparam int LOSS_W   = 16;
  localparam int JIT_W    = 16;
  localparam int DELAY_W  = 12;

  // default depth of the jitter window
  localparam int WINDOW_DEF = 100;

  // register indexes on the config port
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX    = 2'd2;

  // register reset values
  localparam logic [DELAY_W-1:0] TARGET_RST = 12'd60;
  localparam logic [DELAY_W-1:0] MIN_RST    = 12'd20;
  localparam logic [DELAY_W-1:0] MAX_RST    = 12'd200;

  // condition thresholds (loss in Q0.16, jitter in Q12.4)
  localparam logic [LOSS_W-1:0] LOSS_BAD  = 16'd3276;
  localparam logic [LOSS_W-1:0] LOSS_GOOD = 16'd655;
  localparam logic [JIT_W-1:0]  JIT_BAD   = 16'd480;
  localparam logic [JIT_W-1:0]  JIT_GOOD  = 16'd160;

  // changes in ms up to this size are not applied
  localparam logic [DELAY_W-1:0] HYST_MS = 12'd5;

  // delay scaling divider: dividend holds cur*6, cur*9 or cur, divisor holds 5, 10 or 1
  localparam int DLY_DW = 16;
  localparam int DLY_VW = 4;
  localparam logic [DLY_VW-1:0] DIV_UP   = 4'd5;
  localparam logic [DLY_VW-1:0] DIV_DOWN = 4'd10;
  localparam logic [DLY_VW-1:0] DIV_KEEP = 4'd1;

  typedef struct packed {
    logic [LOSS_W-1:0] packet_loss;
    logic [JIT_W-1:0]  jitter;
  } in_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] buffer_ms;
    logic [JIT_W-1:0]   average_jitter;
  } out_item_t;

endpackage

// ===== src/apdc_ram.sv =====
`timescale 1ns / 1ps

module apdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/apdc_sdiv.sv =====
`timescale 1ns / 1ps

module apdc_sdiv #(
  parameter int DW = 23,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] divr;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;

  logic [VW:0] shifted;
  logic [VW:0] trial;
  logic        ge;
  logic [DW:0] quo_ext;

  // one restoring step: bring in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem, quo[DW-1]};
    trial   = shifted - {1'b0, divr};
    ge      = (shifted >= {1'b0, divr});
    quo_ext = {quo, ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      divr <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem <= ge ? trial[VW-1:0] : shifted[VW-1:0];
      quo <= quo_ext[DW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== src/adaptive_playout_delay_control.sv =====
`timescale 1ns / 1ps

// Adaptive playout delay control. Each input beat is one quality report
// (loss fraction, jitter); each report gives exactly one output beat with the
// updated playout delay and the truncated mean jitter over the last WINDOW
// reports. One report is handled at a time; the window average is formed by a
// bit-serial divider one quotient bit per cycle, and the delay scaling runs
// on a second, shorter serial divider in parallel. in_stall is low only
// between reports. The result waits in an output register until taken. The
// jitter window sits in a RAM that needs no clearing after reset. Config
// writes must be made only while idle; the block itself does not enforce
// this. Writing the target register reloads the current delay.

module adaptive_playout_delay_control #(
  parameter int WINDOW = apdc_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  apdc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output apdc_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [apdc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [apdc_pkg::DELAY_W-1:0]   cfg_data
);

  import apdc_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 65536);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state;
  logic [DELAY_W-1:0] cur;
  logic [DELAY_W-1:0] min_ms;
  logic [DELAY_W-1:0] max_ms;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [SLOT_W-1:0]  slot;
  in_item_t           item;

  logic [JIT_W-1:0]   old_jit;
  logic               full;
  logic [CNT_W-1:0]   count_next;
  logic [SUM_W-1:0]   sum_next;
  logic [SLOT_W-1:0]  slot_next;
  logic               bad;
  logic               good;
  logic [DLY_DW-1:0]  dly_dividend;
  logic [DLY_VW-1:0]  dly_divisor;

  logic               avg_busy;
  logic [SUM_W-1:0]   avg_q;
  logic               dly_busy;
  logic [DLY_DW-1:0]  dly_q;

  logic [DELAY_W-1:0] cand_hi;
  logic [DELAY_W-1:0] cand;
  logic [DELAY_W-1:0] diff;
  logic [DELAY_W-1:0] cur_next;
  logic               push;
  logic               fin;

  assign in_stall = (state != S_IDLE);
  assign push     = (state == S_PUSH);
  assign fin      = (state == S_FIN) && (!out_valid || !out_stall);

  // jitter window
  apdc_ram #(
    .WIDTH (JIT_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_window (
    .clk   (clk),
    .we    (push),
    .waddr (slot),
    .wdata (item.jitter),
    .raddr (slot),
    .rdata (old_jit)
  );

  // window bookkeeping and choice of delay scaling
  always_comb begin
    full       = (count == CNT_W'(WINDOW));
    count_next = full ? count : count + 1'b1;
    sum_next   = sum - (full ? SUM_W'(old_jit) : '0) + SUM_W'(item.jitter);
    slot_next  = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

    bad  = (item.packet_loss > LOSS_BAD) || (item.jitter > JIT_BAD);
    good = (item.packet_loss <= LOSS_GOOD) && (item.jitter < JIT_GOOD);

    if (bad) begin
      dly_dividend = (DLY_DW'(cur) << 2) + (DLY_DW'(cur) << 1);
      dly_divisor  = DIV_UP;
    end else if (good) begin
      dly_dividend = (DLY_DW'(cur) << 3) + DLY_DW'(cur);
      dly_divisor  = DIV_DOWN;
    end else begin
      dly_dividend = DLY_DW'(cur);
      dly_divisor  = DIV_KEEP;
    end
  end

  // window mean
  apdc_sdiv #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_avg_div (
    .clk      (clk),
    .rst      (rst),
    .start    (push),
    .dividend (sum_next),
    .divisor  (count_next),
    .busy     (avg_busy),
    .quotient (avg_q)
  );

  // delay scaling
  apdc_sdiv #(
    .DW (DLY_DW),
    .VW (DLY_VW)
  ) u_dly_div (
    .clk      (clk),
    .rst      (rst),
    .start    (push),
    .dividend (dly_dividend),
    .divisor  (dly_divisor),
    .busy     (dly_busy),
    .quotient (dly_q)
  );

  // clamp (min wins) and small-change filter
  always_comb begin
    cand_hi  = (dly_q > DLY_DW'(max_ms)) ? max_ms : dly_q[DELAY_W-1:0];
    cand     = (cand_hi < min_ms) ? min_ms : cand_hi;
    diff     = (cand > cur) ? cand - cur : cur - cand;
    cur_next = (diff > HYST_MS) ? cand : cur;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!avg_busy && !dly_busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // report capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // window state and delay
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sum    <= '0;
      slot   <= '0;
      cur    <= TARGET_RST;
      min_ms <= MIN_RST;
      max_ms <= MAX_RST;
    end else begin
      if (push) begin
        count <= count_next;
        sum   <= sum_next;
        slot  <= slot_next;
      end
      if (fin) begin
        cur <= cur_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET: cur    <= cfg_data;
          REG_MIN:    min_ms <= cfg_data;
          REG_MAX:    max_ms <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data.buffer_ms      <= cur_next;
      out_data.average_jitter <= avg_q[JIT_W-1:0];
    end
  end

endmodule
